>>> sv/coupled_fourier_potential_eval_assert.svh
// Assertion macros for the coupled Fourier potential evaluator.
// No dependencies; included by coupled_fourier_potential_eval, the module that carries assertions.
`ifndef COUPLED_FOURIER_POTENTIAL_EVAL_ASSERT_SVH
`define COUPLED_FOURIER_POTENTIAL_EVAL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CFP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CFP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> sv/cfp_pkg.sv
// Types and constants for the coupled Fourier potential evaluator.
// No dependencies.
package cfp_pkg;
  typedef struct packed {
    logic        cmd;
    logic [7:0]  coef_index;
    logic signed [31:0] coef_value;
    logic [15:0] angle_0;
    logic [15:0] angle_1;
    logic [15:0] angle_2;
    logic [15:0] angle_3;
  } cfp_in_t;

  typedef struct packed {
    logic [30:0] potential;
    logic        clamped_to_zero;
  } cfp_out_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;
  localparam logic [0:0] REG_HARMONICS = 1'b0;
  localparam logic [0:0] REG_ANGLES    = 1'b1;

  localparam int CordicSteps = 16;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [17:0] TrigOne = 18'sd32768;

  function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
    logic signed [33:0] r;
    case (i)
      4'd0: r = 34'sd536870912;  4'd1: r = 34'sd316933406;
      4'd2: r = 34'sd167458907;  4'd3: r = 34'sd85004756;
      4'd4: r = 34'sd42667331;   4'd5: r = 34'sd21354465;
      4'd6: r = 34'sd10679838;   4'd7: r = 34'sd5340245;
      4'd8: r = 34'sd2670163;    4'd9: r = 34'sd1335087;
      4'd10: r = 34'sd667544;    4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;    4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41721;     4'd15: r = 34'sd20861;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round a Q2.30 value half up to Q2.15 and limit to one.
  function automatic logic signed [17:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32768) r = 34'sd32768;
    if (r < -34'sd32768) r = -34'sd32768;
    return r[17:0];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_CONST, ST_TERM, ST_DRAIN, ST_DONE
  } cfp_state_e;
endpackage

>>> sv/cfp_cordic.sv
// Iterative CORDIC: cos and sin in Q2.15 of a 32-bit phase, one step a cycle.
// Depends on cfp_pkg.
module cfp_cordic import cfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [31:0] phase_i,
  output logic done_o,
  output logic signed [17:0] cos_o,
  output logic signed [17:0] sin_o
);
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0] quad_q, quad_d;
  logic [3:0] step_q, step_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic signed [17:0] cc, ss;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; quad_d = quad_q;
    step_d = step_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = CordicGain; y_d = '0;
      z_d = {4'd0, phase_i[29:0]};
      quad_d = phase_i[31:30];
      step_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - (y_q >>> step_q); y_d = y_q + (x_q >>> step_q);
        z_d = z_q - atan_turn(step_q);
      end else begin
        x_d = x_q + (y_q >>> step_q); y_d = y_q - (x_q >>> step_q);
        z_d = z_q + atan_turn(step_q);
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'(CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; quad_q <= quad_d;
  end

  always_comb begin
    cc = to_q15(x_q);
    ss = to_q15(y_q);
    case (quad_q)
      2'd0: begin cos_o = cc;  sin_o = ss;  end
      2'd1: begin cos_o = -ss; sin_o = cc;  end
      2'd2: begin cos_o = -cc; sin_o = -ss; end
      default: begin cos_o = ss; sin_o = -cc; end
    endcase
  end
  assign done_o = done_q;
endmodule

>>> sv/cfp_coef_mem.sv
// Coefficient store: one write port, one registered read port.
// Depends on cfp_pkg.
module cfp_coef_mem import cfp_pkg::*; #(
  parameter int Depth = 256
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [31:0] rdata_o
);
  logic [31:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> sv/coupled_fourier_potential_eval.sv
// Coupled Fourier potential evaluator. A write transaction stores one coefficient. An
// evaluate transaction first runs the CORDIC for every angle and harmonic in use (up to
// MAX_ANGLES*MAX_HARMONICS runs), then walks the basis terms with one coefficient read
// and one multiply-accumulate per cycle; the CORDIC unit and the single memory read port
// set how long it takes. One evaluation is in flight at a time; the result waits in an
// output register.
module coupled_fourier_potential_eval import cfp_pkg::*; #(
  parameter int MAX_ANGLES = 4,
  parameter int MAX_HARMONICS = 4,
  parameter int COEF_DEPTH = 256,
  parameter int PHASE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cfp_in_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cfp_out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [2:0] cfg_data_i
);
  `include "coupled_fourier_potential_eval_assert.svh"
  localparam int AW = $clog2(COEF_DEPTH);
  localparam int NT = MAX_ANGLES * MAX_HARMONICS;
  localparam int TW = $clog2(NT + 1);
  localparam int HW = $clog2(MAX_HARMONICS + 1);
  localparam int GW = $clog2(MAX_ANGLES + 1);
  localparam int AIW = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
  localparam int NumInAngles = 4;

  logic [2:0] harm_q, ang_q;
  logic [HW-1:0] ne;
  logic [GW-1:0] na;
  cfp_state_e state_q, state_d;
  logic signed [17:0] cs_q [NT];
  logic signed [17:0] sn_q [NT];
  logic [PHASE_BITS-1:0] ang_v_q [MAX_ANGLES];
  logic [NumInAngles-1:0][15:0] in_angles;
  logic [GW-1:0] i_q, i_d, j_q, j_d;
  logic [HW-1:0] n_q, n_d, m_q, m_d;
  logic sel_q, sel_d;
  logic [AW:0] k_q, k_d;
  logic [PHASE_BITS-1:0] ph_q, ph_d;
  logic cor_start, cor_done;
  logic signed [17:0] cor_cos, cor_sin;
  logic [31:0] phase32;
  logic [31:0] rdata;
  logic rd_en_q, rd_in_q;
  logic signed [17:0] trig_d, trig_q;
  logic vld_q;
  logic signed [49:0] mul;
  logic signed [63:0] prod_q, acc_q;
  logic signed [35:0] pair;
  logic out_v_q;
  cfp_out_t out_q;
  logic signed [63:0] rnd;
  logic term_go, accept;
  logic [$clog2(NT)-1:0] ti, tj;

  assign ne = (32'(harm_q) > MAX_HARMONICS) ? HW'(MAX_HARMONICS) : HW'(harm_q);
  assign na = (32'(ang_q) > MAX_ANGLES) ? GW'(MAX_ANGLES) : GW'(ang_q);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || out_v_q;
  assign cfg_ready_o = 1'b1;
  assign in_angles = {in_data_i.angle_3, in_data_i.angle_2, in_data_i.angle_1,
                      in_data_i.angle_0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harm_q <= 3'd1; ang_q <= 3'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_HARMONICS) harm_q <= cfg_data_i;
      else ang_q <= cfg_data_i;
    end
  end

  cfp_coef_mem #(.Depth(COEF_DEPTH)) u_mem (
    .clk_i(clk_i),
    .we_i(accept && in_data_i.cmd == CMD_WRITE && 32'(in_data_i.coef_index) < COEF_DEPTH),
    .waddr_i(AW'(in_data_i.coef_index)),
    .wdata_i(in_data_i.coef_value),
    .raddr_i(k_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // The CORDIC loads its phase on the same edge that moves ph_d into ph_q.
  assign phase32 = {ph_d, {(32 - PHASE_BITS){1'b0}}};
  cfp_cordic u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cor_start), .phase_i(phase32),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  assign ti = $clog2(NT)'(32'(i_q) * MAX_HARMONICS + 32'(n_q) - 1);
  assign tj = $clog2(NT)'(32'(j_q) * MAX_HARMONICS + 32'(m_q) - 1);

  // Next state and term walk.
  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; n_d = n_q; m_d = m_q;
    sel_d = sel_q; k_d = k_q; ph_d = ph_q;
    case (state_q)
      ST_IDLE: if (accept && in_data_i.cmd == CMD_EVAL) begin
        i_d = '0; n_d = HW'(1); k_d = '0;
        ph_d = PHASE_BITS'(in_data_i.angle_0);
        state_d = (na == '0 || ne == '0) ? ST_CONST : ST_TRIG;
      end
      ST_TRIG: if (cor_done) begin
        if (n_q == ne) begin
          n_d = HW'(1);
          if (i_q + GW'(1) == na) begin
            i_d = '0; state_d = ST_CONST;
          end else begin
            i_d = i_q + GW'(1);
          end
        end else begin
          n_d = n_q + HW'(1);
        end
        ph_d = PHASE_BITS'(32'(n_d) * 32'(ang_v_q[i_d[AIW-1:0]]));
      end
      ST_CONST: begin
        k_d = k_q + 1'b1; i_d = '0; n_d = HW'(1); j_d = '0; m_d = '0; sel_d = 1'b0;
        state_d = (na == '0 || ne == '0) ? ST_DRAIN : ST_TERM;
      end
      ST_TERM: begin
        // Past the end of the store the index parks, and those terms add nothing.
        k_d = (32'(k_q) < COEF_DEPTH) ? k_q + 1'b1 : k_q;
        sel_d = !sel_q;
        if (sel_q) begin
          if (m_q == '0) begin
            // Single-angle terms of angle i.
            if (n_q == ne) begin
              n_d = HW'(1);
              if (i_q == '0) begin
                if (na == GW'(1)) state_d = ST_DRAIN;
                else begin i_d = GW'(1); end
              end else begin
                j_d = '0; m_d = HW'(1);
              end
            end else n_d = n_q + HW'(1);
          end else begin
            if (m_q == ne) begin
              m_d = HW'(1);
              if (j_q + GW'(1) == i_q) begin
                j_d = '0;
                if (n_q == ne) begin
                  n_d = HW'(1); m_d = '0;
                  if (i_q + GW'(1) == na) state_d = ST_DRAIN;
                  else i_d = i_q + GW'(1);
                end else n_d = n_q + HW'(1);
              end else j_d = j_q + GW'(1);
            end else m_d = m_q + HW'(1);
          end
        end
      end
      ST_DRAIN: if (!rd_en_q && !vld_q) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    cor_start = 1'b0; term_go = 1'b0;
    case (state_q)
      ST_IDLE: cor_start = accept && in_data_i.cmd == CMD_EVAL && na != '0 && ne != '0;
      ST_TRIG: cor_start = cor_done && state_d == ST_TRIG;
      ST_CONST, ST_TERM: term_go = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    pair = '0;
    if (state_q == ST_CONST) trig_d = TrigOne;
    else if (m_q == '0) trig_d = sel_q ? sn_q[ti] : cs_q[ti];
    else begin
      pair = sel_q ? (sn_q[ti] * sn_q[tj]) : (cs_q[ti] * cs_q[tj]);
      pair = (pair + 36'sd16384) >>> 15;
      trig_d = pair[17:0];
    end
  end

  // The coefficient and its trig factor arrive together, in the cycle after the read.
  assign mul = $signed(rdata) * trig_q;
  assign rnd = (acc_q + 64'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.cmd == CMD_EVAL) begin
      for (int a = 0; a < MAX_ANGLES; a++) begin
        ang_v_q[a] <= (a < NumInAngles) ? PHASE_BITS'(in_angles[2'(a)]) : '0;
      end
    end
    if (state_q == ST_TRIG && cor_done) begin
      cs_q[ti] <= cor_cos; sn_q[ti] <= cor_sin;
    end
    trig_q <= trig_d;
    prod_q <= 64'(mul);
    if (state_q == ST_DONE) begin
      out_q.clamped_to_zero <= rnd[63];
      out_q.potential <= rnd[63] ? '0 :
        (rnd > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : rnd[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; i_q <= '0; j_q <= '0; n_q <= '0; m_q <= '0;
      sel_q <= 1'b0; k_q <= '0; ph_q <= '0;
      rd_en_q <= 1'b0; rd_in_q <= 1'b0; vld_q <= 1'b0;
      acc_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; n_q <= n_d; m_q <= m_d;
      sel_q <= sel_d; k_q <= k_d; ph_q <= ph_d;
      rd_en_q <= term_go;
      rd_in_q <= term_go && (32'(k_q) < COEF_DEPTH);
      vld_q <= rd_en_q && rd_in_q;
      if (state_q == ST_IDLE && accept) acc_q <= '0;
      else if (vld_q) acc_q <= acc_q + prod_q;
      if (state_q == ST_DONE) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  `CFP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o)
  `CFP_ASSERT_NEXT(a_done_gives_out, clk_i, rst_ni, state_q == ST_DONE, out_v_q)
  `CFP_ASSERT_IMP(a_clamp_zero, clk_i, rst_ni, out_v_q && out_q.clamped_to_zero,
    out_q.potential == '0)
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the coupled Fourier potential evaluator.
// Depends on cfp_pkg and coupled_fourier_potential_eval; predicts every potential in
// the testbench itself and compares each output transaction with it.
module testbench;
  import cfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = 256;
  localparam int NumAngles = 4;
  localparam int NumHarm = 4;
  localparam int SettleCycles = 600;
  localparam longint CycleLimit = 2_500_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cfp_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cfp_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = REG_HARMONICS;
  logic [2:0] cfg_data_i = '0;

  coupled_fourier_potential_eval dut (.*);

  logic signed [31:0] coef_copy [StoreDepth];
  logic [2:0] harm_setting = 3'd1;
  logic [2:0] angle_setting = 3'd1;
  cfp_out_t pending_potentials[$];
  int mismatches = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 20);
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cfp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_potentials.size() == 0) begin
        report_mismatch("unexpected potential", out_data_o.potential, -1);
      end else begin
        want = pending_potentials.pop_front();
        if (out_data_o.potential !== want.potential)
          report_mismatch("potential", out_data_o.potential, want.potential);
        if (out_data_o.clamped_to_zero !== want.clamped_to_zero)
          report_mismatch("clamped_to_zero", out_data_o.clamped_to_zero,
                          want.clamped_to_zero);
      end
    end
  end

  function automatic longint round_trig(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // CORDIC rotation over one quadrant, then the quadrant from the top phase bits.
  task automatic cordic_cos_sin(input logic [31:0] phase, output longint c, output longint s);
    longint x, y, z, dx, dy, cc, ss;
    longint angle_steps [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                 333772, 166886, 83443, 41721, 20861};
    x = 652032874;
    y = 0;
    z = longint'(phase & 32'h3FFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= angle_steps[i];
      end else begin
        x += dx; y -= dy; z += angle_steps[i];
      end
    end
    cc = round_trig(x);
    ss = round_trig(y);
    case (phase[31:30])
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endtask

  task automatic predict_potential(input cfp_in_t item, output cfp_out_t res);
    longint cs [NumAngles][NumHarm+1];
    longint sn [NumAngles][NumHarm+1];
    logic [15:0] angles [NumAngles];
    int na, ne, k;
    logic [31:0] phase;
    longint acc, r, pc, ps;
    angles = '{item.angle_0, item.angle_1, item.angle_2, item.angle_3};
    na = (angle_setting > NumAngles) ? NumAngles : angle_setting;
    ne = (harm_setting > NumHarm) ? NumHarm : harm_setting;
    for (int i = 0; i < na; i++)
      for (int n = 1; n <= ne; n++) begin
        phase = {16'(n * angles[i]), 16'h0};
        cordic_cos_sin(phase, cs[i][n], sn[i][n]);
      end
    acc = longint'(coef_copy[0]) * 32768;
    k = 1;
    for (int i = 0; i < na; i++) begin
      for (int n = 1; n <= ne; n++) begin
        acc += longint'(coef_copy[k]) * cs[i][n];
        acc += longint'(coef_copy[k+1]) * sn[i][n];
        k += 2;
      end
      for (int n = 1; n <= ne; n++)
        for (int j = 0; j < i; j++)
          for (int m = 1; m <= ne; m++) begin
            pc = (cs[i][n] * cs[j][m] + 16384) >>> 15;
            ps = (sn[i][n] * sn[j][m] + 16384) >>> 15;
            acc += longint'(coef_copy[k]) * pc;
            acc += longint'(coef_copy[k+1]) * ps;
            k += 2;
          end
    end
    r = (acc + 16384) >>> 15;
    if (r < 0) begin
      res.potential = '0;
      res.clamped_to_zero = 1'b1;
    end else begin
      if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
      res.potential = r[30:0];
      res.clamped_to_zero = 1'b0;
    end
  endtask

  // Valid is left high after acceptance; the next send or drain decides its level.
  task automatic send_item(input cfp_in_t item);
    cfp_out_t res;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.cmd == CMD_WRITE) begin
      coef_copy[item.coef_index] = item.coef_value;
    end else begin
      predict_potential(item, res);
      pending_potentials = {pending_potentials, res};
    end
  endtask

  task automatic wait_results(input bit settle);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_potentials.size() != 0) @(posedge clk_i);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [2:0] value);
    wait_results(1'b1);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_HARMONICS) harm_setting = value;
    else angle_setting = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic cfp_in_t random_item(input logic cmd);
    cfp_in_t item;
    item.cmd = cmd;
    item.coef_index = 8'($urandom);
    case ($urandom_range(0, 9))
      0: item.coef_value = 32'sh7FFF_FFFF;
      1: item.coef_value = 32'sh8000_0000;
      2, 3: item.coef_value = $urandom;
      default: item.coef_value = $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh000F_FFFF;
    endcase
    item.angle_0 = 16'($urandom);
    item.angle_1 = 16'($urandom);
    item.angle_2 = 16'($urandom);
    item.angle_3 = 16'($urandom);
    return item;
  endfunction

  function automatic cfp_in_t write_item(input int idx, input logic signed [31:0] value);
    cfp_in_t item;
    item = random_item(CMD_WRITE);
    item.coef_index = 8'(idx);
    item.coef_value = value;
    return item;
  endfunction

  function automatic cfp_in_t eval_item(input logic [15:0] angle);
    cfp_in_t item;
    item = random_item(CMD_EVAL);
    item.angle_0 = angle;
    return item;
  endfunction

  // Every store entry gets a value, so no evaluation reads an unwritten one.
  task automatic test_store_load;
    for (int i = 0; i < StoreDepth; i++) send_item(write_item(i, $signed($urandom)));
  endtask

  task automatic test_directed;
    logic [15:0] quadrant_angles [6] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                                        16'hC000, 16'hFFFF};
    send_item(write_item(0, 32'sh7FFF_FFFF));
    send_item(write_item(1, 32'sh7FFF_FFFF));
    send_item(write_item(2, 32'sh7FFF_FFFF));
    send_item(eval_item(16'h0000));    // sum above the top saturates
    send_item(write_item(0, 32'sh8000_0000));
    send_item(write_item(1, 32'sh0));
    send_item(write_item(2, 32'sh0));
    send_item(eval_item(16'h1234));    // negative sum is clamped
    send_item(write_item(0, 32'sh0001_0000));
    send_item(write_item(1, 32'sh0001_0000));
    send_item(write_item(2, 32'shFFFF_0000));
    foreach (quadrant_angles[i]) send_item(eval_item(quadrant_angles[i]));
    write_register(REG_HARMONICS, 3'd0);   // only the constant term is left
    send_item(eval_item(16'hFFFF));
    write_register(REG_ANGLES, 3'd7);      // both registers above their limits
    write_register(REG_HARMONICS, 3'd7);
    send_item(eval_item(16'h5555));
    write_register(REG_ANGLES, 3'd0);
    send_item(eval_item(16'hAAAA));
  endtask

  task automatic test_random_phases;
    logic [2:0] harm_plan [9] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd4, 3'd1, 3'd4};
    logic [2:0] angle_plan [9] = '{3'd4, 3'd1, 3'd3, 3'd2, 3'd7, 3'd0, 3'd1, 3'd4, 3'd3};
    for (int p = 0; p < 9; p++) begin
      write_register(REG_HARMONICS, harm_plan[p]);
      write_register(REG_ANGLES, angle_plan[p]);
      no_idle = (p == 4);
      for (int i = 0; i < 52; i++) begin
        send_item(random_item($urandom_range(0, 99) < 55 ? CMD_EVAL : CMD_WRITE));
        if (i == 26) wait_results(1'b0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_store_load();
    test_directed();
    test_random_phases();
    wait_results(1'b1);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
